// File: sv/rcfr_pkg.sv
// Shared types, constants and the CRC-16 byte update for the repetition-coded frame receiver.
package rcfr_pkg;

    localparam int REPEAT_FACTOR_DEFAULT = 5;

    localparam logic [7:0]  START_BYTE_RESET = 8'h7E;
    localparam logic [7:0]  MAX_LENGTH_RESET = 8'd64;
    localparam logic [15:0] CRC_INIT         = 16'hFFFF;
    localparam logic [15:0] CRC_POLY         = 16'h1021;

    // Configuration register indexes.
    localparam logic CFG_START_BYTE = 1'b0;
    localparam logic CFG_MAX_LENGTH = 1'b1;

    typedef enum logic [1:0] {
        KIND_DATA      = 2'd0,
        KIND_OK        = 2'd1,
        KIND_CRC_ERR   = 2'd2,
        KIND_FRAME_ERR = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
        logic        last;
        logic [15:0] crc_rx;
        logic [15:0] crc_local;
        logic [31:0] ok_total;
        logic [31:0] crc_error_total;
        logic [31:0] framing_error_total;
        logic [31:0] corrected_total;
    } result_t;

    // CRC-16/CCITT-FALSE, one byte, MSB first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// File: sv/repetition_coded_frame_receiver.sv
// Top level of the repetition-coded frame receiver: framing, voting, CRC check and output skid.
//
// Usage: raw link bytes arrive on the input channel (in_valid/in_ready/in_byte), one
// transaction per byte. The block hunts for start_byte, then majority-votes every
// REPEAT_FACTOR bytes into one decoded byte: the length, the payload, the CRC low byte
// and the CRC high byte. Each decoded payload byte leaves on the output channel as a
// kind-data transaction; the frame closes with one verdict transaction (frame ok or
// CRC error, last set). A length of zero or above max_length yields a framing-error
// transaction and the hunt restarts. The four 32-bit totals ride on every result.
// Throughput is one input byte per clock while the skid register is empty (in_ready high).
// Each result is registered into the output register, or into the skid while the receiver stalls.
// The output register is backed by a one-entry skid register, so one more result can
// be taken in while the receiver stalls; in_ready falls only
// when both are full and rises again as soon as the receiver takes a result.
// The configuration port (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready and
// should be written only while no frame is in progress.
// Reset puts the block in the hunt with start_byte 0x7E, max_length 64 and all totals
// at zero; the output and skid registers come up empty.
module repetition_coded_frame_receiver #(
    parameter int REPEAT_FACTOR = rcfr_pkg::REPEAT_FACTOR_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  result_kind,
    output logic [7:0]  data_byte,
    output logic        last,
    output logic [15:0] crc_received,
    output logic [15:0] crc_computed,
    output logic [31:0] ok_total,
    output logic [31:0] crc_error_total,
    output logic [31:0] framing_error_total,
    output logic [31:0] corrected_total
);

    localparam int PW = $clog2(REPEAT_FACTOR);
    localparam int SW = $clog2(REPEAT_FACTOR - 1);
    localparam logic [PW-1:0] POS_LAST = PW'(REPEAT_FACTOR - 1);

    // One-hot receive mode.
    typedef enum logic [2:0] {
        MODE_HUNT = 3'b001,
        MODE_LEN  = 3'b010,
        MODE_BODY = 3'b100
    } mode_t;

    // Configuration registers.
    logic [7:0] start_byte_reg;
    logic [7:0] max_length_reg;

    // Frame state.
    mode_t       mode_reg,         mode_next;
    logic [PW-1:0] vote_pos_reg,   vote_pos_next;
    logic [7:0]  frame_length_reg, frame_length_next;
    logic [8:0]  group_index_reg,  group_index_next;
    logic [15:0] crc_reg,          crc_next;
    logic [7:0]  crc_low_reg,      crc_low_next;
    logic [31:0] ok_reg,           ok_next;
    logic [31:0] crc_err_reg,      crc_err_next;
    logic [31:0] frame_err_reg,    frame_err_next;
    logic [31:0] corrected_reg,    corrected_next;

    // Earlier copies of the current group; the last copy is taken straight from the input.
    logic [REPEAT_FACTOR-2:0][7:0] store_reg;
    logic                          store_we;

    logic [REPEAT_FACTOR-1:0][7:0] copies;
    logic [7:0]                    voted;
    logic [3:0]                    disagree;

    rcfr_pkg::result_t res;
    logic              res_valid;

    // Output register and its skid register.
    rcfr_pkg::result_t out_reg;
    rcfr_pkg::result_t skid_reg;
    logic              out_valid_reg;
    logic              skid_valid_reg;
    logic              out_load_skid;
    logic              out_load_res;
    logic              skid_load;

    logic in_fire;
    logic out_fire;

    assign cfg_ready = 1'b1;
    assign in_ready  = ~skid_valid_reg;
    assign in_fire   = in_valid & in_ready;
    assign out_fire  = out_valid_reg & out_ready;

    assign copies = {in_byte, store_reg};

    rcfr_vote #(
        .REPEAT_FACTOR(REPEAT_FACTOR)
    ) u_vote (
        .copies         (copies),
        .decoded        (voted),
        .disagree_count (disagree)
    );

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            start_byte_reg <= rcfr_pkg::START_BYTE_RESET;
            max_length_reg <= rcfr_pkg::MAX_LENGTH_RESET;
        end
        else if (cfg_valid) begin
            unique case (cfg_index)
                rcfr_pkg::CFG_START_BYTE: start_byte_reg <= cfg_data;
                rcfr_pkg::CFG_MAX_LENGTH: max_length_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Per-byte framing logic. All of it settles within the accepting cycle.
    always_comb begin
        mode_next         = mode_reg;
        vote_pos_next     = vote_pos_reg;
        frame_length_next = frame_length_reg;
        group_index_next  = group_index_reg;
        crc_next          = crc_reg;
        crc_low_next      = crc_low_reg;
        ok_next           = ok_reg;
        crc_err_next      = crc_err_reg;
        frame_err_next    = frame_err_reg;
        corrected_next    = corrected_reg;
        store_we          = 1'b0;
        res_valid         = 1'b0;
        res               = '0;
        res.kind          = rcfr_pkg::KIND_DATA;

        if (in_fire) begin
            unique case (mode_reg) inside
                MODE_LEN, MODE_BODY:
                begin
                    if (vote_pos_reg != POS_LAST) begin
                        store_we      = 1'b1;
                        vote_pos_next = vote_pos_reg + 1'b1;
                    end
                    else begin
                        vote_pos_next  = '0;
                        corrected_next = corrected_reg + 32'(disagree);
                        if (mode_reg == MODE_LEN) begin
                            if (voted == 8'd0 || voted > max_length_reg) begin
                                frame_err_next    = frame_err_reg + 32'd1;
                                mode_next         = MODE_HUNT;
                                frame_length_next = '0;
                                group_index_next  = '0;
                                crc_next          = rcfr_pkg::CRC_INIT;
                                crc_low_next      = '0;
                                res_valid         = 1'b1;
                                res.kind          = rcfr_pkg::KIND_FRAME_ERR;
                                res.last          = 1'b1;
                            end
                            else begin
                                frame_length_next = voted;
                                group_index_next  = '0;
                                crc_next          = rcfr_pkg::CRC_INIT;
                                mode_next         = MODE_BODY;
                            end
                        end
                        else if (group_index_reg < {1'b0, frame_length_reg}) begin
                            crc_next         = rcfr_pkg::crc_byte(crc_reg, voted);
                            group_index_next = group_index_reg + 9'd1;
                            res_valid        = 1'b1;
                            res.kind         = rcfr_pkg::KIND_DATA;
                            res.data         = voted;
                        end
                        else if (group_index_reg == {1'b0, frame_length_reg}) begin
                            crc_low_next     = voted;
                            group_index_next = group_index_reg + 9'd1;
                        end
                        else begin
                            // CRC high byte: close the frame with a verdict.
                            res_valid     = 1'b1;
                            res.last      = 1'b1;
                            res.crc_rx    = {voted, crc_low_reg};
                            res.crc_local = crc_reg;
                            if ({voted, crc_low_reg} == crc_reg) begin
                                ok_next  = ok_reg + 32'd1;
                                res.kind = rcfr_pkg::KIND_OK;
                            end
                            else begin
                                crc_err_next = crc_err_reg + 32'd1;
                                res.kind     = rcfr_pkg::KIND_CRC_ERR;
                            end
                            mode_next         = MODE_HUNT;
                            frame_length_next = '0;
                            group_index_next  = '0;
                            crc_next          = rcfr_pkg::CRC_INIT;
                            crc_low_next      = '0;
                        end
                    end
                end
                default:
                begin
                    // Hunt; a start byte opens the length group.
                    if (in_byte == start_byte_reg) begin
                        mode_next     = MODE_LEN;
                        vote_pos_next = '0;
                    end
                end
            endcase
        end

        res.ok_total            = ok_next;
        res.crc_error_total     = crc_err_next;
        res.framing_error_total = frame_err_next;
        res.corrected_total     = corrected_next;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mode_reg         <= MODE_HUNT;
            vote_pos_reg     <= '0;
            frame_length_reg <= '0;
            group_index_reg  <= '0;
            crc_reg          <= rcfr_pkg::CRC_INIT;
            crc_low_reg      <= '0;
            ok_reg           <= '0;
            crc_err_reg      <= '0;
            frame_err_reg    <= '0;
            corrected_reg    <= '0;
        end
        else begin
            mode_reg         <= mode_next;
            vote_pos_reg     <= vote_pos_next;
            frame_length_reg <= frame_length_next;
            group_index_reg  <= group_index_next;
            crc_reg          <= crc_next;
            crc_low_reg      <= crc_low_next;
            ok_reg           <= ok_next;
            crc_err_reg      <= crc_err_next;
            frame_err_reg    <= frame_err_next;
            corrected_reg    <= corrected_next;
        end
    end

    always_ff @(posedge clk) begin
        if (store_we) begin
            store_reg[vote_pos_reg[SW-1:0]] <= in_byte;
        end
    end

    // The output register refills from the skid first; a new result only lands in the
    // skid while the output register is held by the receiver.
    always_comb begin
        out_load_skid = 1'b0;
        out_load_res  = 1'b0;
        skid_load     = 1'b0;
        if (out_fire || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_load_skid = 1'b1;
            end
            else if (res_valid) begin
                out_load_res = 1'b1;
            end
        end
        else if (res_valid) begin
            skid_load = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else begin
            if (out_fire || !out_valid_reg) begin
                out_valid_reg <= out_load_skid | out_load_res;
            end
            if (out_load_skid) begin
                skid_valid_reg <= 1'b0;
            end
            else if (skid_load) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (out_load_skid) begin
            out_reg <= skid_reg;
        end
        else if (out_load_res) begin
            out_reg <= res;
        end
        if (skid_load) begin
            skid_reg <= res;
        end
    end

    assign out_valid           = out_valid_reg;
    assign result_kind         = out_reg.kind;
    assign data_byte           = out_reg.data;
    assign last                = out_reg.last;
    assign crc_received        = out_reg.crc_rx;
    assign crc_computed        = out_reg.crc_local;
    assign ok_total            = out_reg.ok_total;
    assign crc_error_total     = out_reg.crc_error_total;
    assign framing_error_total = out_reg.framing_error_total;
    assign corrected_total     = out_reg.corrected_total;

endmodule

// File: sv/rcfr_vote.sv
// Bitwise majority vote over one group of repeated byte copies, with a disagreement count.
module rcfr_vote #(
    parameter int REPEAT_FACTOR = rcfr_pkg::REPEAT_FACTOR_DEFAULT
) (
    input  logic [REPEAT_FACTOR-1:0][7:0] copies,
    output logic [7:0]                    decoded,
    output logic [3:0]                    disagree_count
);

    localparam int CW   = $clog2(REPEAT_FACTOR + 1);
    localparam int HALF = REPEAT_FACTOR / 2;

    logic [7:0][CW-1:0] ones;
    logic [7:0]         any_one;
    logic [7:0]         all_one;

    always_comb begin
        for (int b = 0; b < 8; b++) begin
            ones[b]    = '0;
            any_one[b] = 1'b0;
            all_one[b] = 1'b1;
            for (int k = 0; k < REPEAT_FACTOR; k++) begin
                ones[b]    = ones[b] + CW'(copies[k][b]);
                any_one[b] = any_one[b] | copies[k][b];
                all_one[b] = all_one[b] & copies[k][b];
            end
            decoded[b] = (ones[b] > CW'(HALF));
        end
    end

    // A bit position counts as corrected when its copies are not all equal.
    always_comb begin
        disagree_count = '0;
        for (int b = 0; b < 8; b++) begin
            disagree_count = disagree_count + 4'(any_one[b] & ~all_one[b]);
        end
    end

endmodule

// File: sv/rcfr_checker.sv
// Port-level assertions for the repetition-coded frame receiver, bound to the top level.
module rcfr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  result_kind,
    input logic [7:0]  data_byte,
    input logic        last,
    input logic [15:0] crc_received,
    input logic [15:0] crc_computed
);

    // Every non-data result (verdict or framing error) closes a frame; data results never do.
    a_last_on_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (result_kind != rcfr_pkg::KIND_DATA)))
        else $error("last does not match the result kind");

    // A frame-ok verdict carries matching CRCs, a CRC-error verdict differing ones.
    a_verdict_crc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == rcfr_pkg::KIND_OK || result_kind == rcfr_pkg::KIND_CRC_ERR)
        |-> ((crc_received == crc_computed) == (result_kind == rcfr_pkg::KIND_OK)))
        else $error("verdict disagrees with the CRC fields");

    // Unused fields read as zero: CRC fields on data results, the data byte on all others.
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((result_kind == rcfr_pkg::KIND_DATA)
                       ? (crc_received == 16'd0 && crc_computed == 16'd0)
                       : (data_byte == 8'd0)))
        else $error("unused result field is not zero");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_kind) && $stable(data_byte))
        else $error("output changed while stalled");

endmodule

bind repetition_coded_frame_receiver rcfr_checker u_rcfr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_kind  (result_kind),
    .data_byte    (data_byte),
    .last         (last),
    .crc_received (crc_received),
    .crc_computed (crc_computed)
);

// File: test/testbench.sv
// Self-checking testbench for the repetition-coded frame receiver, with its own frame decoder.
`timescale 1ns / 1ps

module testbench;

    localparam int RF          = rcfr_pkg::REPEAT_FACTOR_DEFAULT;
    localparam int STALL_LIMIT = 2000;

    // Receiver phases as the decoder below tracks them. The fourth code is never
    // entered, and the decoder treats anything but length or body as the hunt.
    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_LENGTH = 2'd1,
        PH_BODY   = 2'd2
    } rx_phase_t;

    // Every input of the block starts at a known value.
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_index = rcfr_pkg::CFG_START_BYTE;
    logic [7:0]  cfg_data  = 8'h00;
    logic        in_valid  = 1'b0;
    logic [7:0]  in_byte   = 8'h00;
    logic        out_ready = 1'b0;

    logic        cfg_ready;
    logic        in_ready;
    logic        out_valid;
    logic [1:0]  result_kind;
    logic [7:0]  data_byte;
    logic        last;
    logic [15:0] crc_received;
    logic [15:0] crc_computed;
    logic [31:0] ok_total;
    logic [31:0] crc_error_total;
    logic [31:0] framing_error_total;
    logic [31:0] corrected_total;

    // Decoder state: configuration, framing position, running CRC and the totals.
    logic [7:0]  start_byte_cfg;
    logic [7:0]  max_length_cfg;
    rx_phase_t   phase;
    int          copy_idx;
    logic [7:0]  copies [RF];
    logic [7:0]  body_len;
    logic [8:0]  payload_idx;
    logic [15:0] crc_acc;
    logic [7:0]  crc_lo;
    logic [31:0] ok_cnt;
    logic [31:0] crc_err_cnt;
    logic [31:0] frame_err_cnt;
    logic [31:0] fixed_bits_cnt;

    // Decoded results still owed by the block, oldest first.
    rcfr_pkg::result_t expected_results [$];

    int          mismatches    = 0;
    int          counted_items = 0;
    int          sent_bytes    = 0;
    bit          in_quiet      = 1'b0;
    bit          out_quiet     = 1'b0;
    int          out_stall_left = 0;
    int          out_cycles    = 0;
    int          idle_cycles   = 0;

    repetition_coded_frame_receiver #(
        .REPEAT_FACTOR(RF)
    ) dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .in_byte             (in_byte),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .result_kind         (result_kind),
        .data_byte           (data_byte),
        .last                (last),
        .crc_received        (crc_received),
        .crc_computed        (crc_computed),
        .ok_total            (ok_total),
        .crc_error_total     (crc_error_total),
        .framing_error_total (framing_error_total),
        .corrected_total     (corrected_total)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // CRC-16/CCITT-FALSE, one data bit at a time, most significant bit first.
    function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0} ^ (fb ? rcfr_pkg::CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    // Idle length for either channel: mostly none or short, now and then long.
    function automatic int pick_gap(input bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 2);
        if (r < 97)
            return $urandom_range(3, 8);
        return $urandom_range(20, 50);
    endfunction

    task automatic restart_hunt();
        phase       = PH_HUNT;
        copy_idx    = 0;
        body_len    = 8'd0;
        payload_idx = 9'd0;
        crc_acc     = rcfr_pkg::CRC_INIT;
        crc_lo      = 8'd0;
    endtask

    task automatic reset_decoder();
        start_byte_cfg = rcfr_pkg::START_BYTE_RESET;
        max_length_cfg = rcfr_pkg::MAX_LENGTH_RESET;
        ok_cnt         = 32'd0;
        crc_err_cnt    = 32'd0;
        frame_err_cnt  = 32'd0;
        fixed_bits_cnt = 32'd0;
        restart_hunt();
    endtask

    // Queues one result; the totals carried are the ones after this byte's update.
    task automatic owe_result(input rcfr_pkg::kind_t kind, input logic [7:0] data,
                              input logic fin,
                              input logic [15:0] crx, input logic [15:0] ccalc);
        rcfr_pkg::result_t r;
        r.kind                = kind;
        r.data                = data;
        r.last                = fin;
        r.crc_rx              = crx;
        r.crc_local           = ccalc;
        r.ok_total            = ok_cnt;
        r.crc_error_total     = crc_err_cnt;
        r.framing_error_total = frame_err_cnt;
        r.corrected_total     = fixed_bits_cnt;
        expected_results.push_back(r);
    endtask

    // Decodes one accepted link byte and records any result it causes.
    task automatic decode_byte(input logic [7:0] b);
        logic [7:0]  v;
        logic [15:0] crx;
        int          ones;
        if (phase != PH_LENGTH && phase != PH_BODY) begin
            if (b == start_byte_cfg) begin
                phase    = PH_LENGTH;
                copy_idx = 0;
            end
            return;
        end

        copies[copy_idx] = b;
        copy_idx++;
        if (copy_idx < RF)
            return;
        copy_idx = 0;

        // Bitwise majority; a bit whose copies are not unanimous counts as corrected.
        v = 8'd0;
        for (int bit_i = 0; bit_i < 8; bit_i++) begin
            ones = 0;
            for (int k = 0; k < RF; k++)
                ones += copies[k][bit_i];
            if (ones != 0 && ones != RF)
                fixed_bits_cnt++;
            v[bit_i] = (ones > RF / 2);
        end

        if (phase == PH_LENGTH) begin
            if (v == 8'd0 || v > max_length_cfg) begin
                frame_err_cnt++;
                restart_hunt();
                owe_result(rcfr_pkg::KIND_FRAME_ERR, 8'd0, 1'b1, 16'd0, 16'd0);
            end else begin
                body_len    = v;
                payload_idx = 9'd0;
                crc_acc     = rcfr_pkg::CRC_INIT;
                phase       = PH_BODY;
            end
            return;
        end

        if (payload_idx < {1'b0, body_len}) begin
            crc_acc = crc16_next(crc_acc, v);
            payload_idx++;
            owe_result(rcfr_pkg::KIND_DATA, v, 1'b0, 16'd0, 16'd0);
        end else if (payload_idx == {1'b0, body_len}) begin
            crc_lo = v;
            payload_idx++;
        end else begin
            crx = {v, crc_lo};
            if (crx == crc_acc) begin
                ok_cnt++;
                owe_result(rcfr_pkg::KIND_OK, 8'd0, 1'b1, crx, crc_acc);
            end else begin
                crc_err_cnt++;
                owe_result(rcfr_pkg::KIND_CRC_ERR, 8'd0, 1'b1, crx, crc_acc);
            end
            restart_hunt();
        end
    endtask

    // Sends one byte on the input channel. Called at a rising edge; returns at the edge
    // that accepts the transaction. Handshakes are sampled on the falling edge so that
    // nothing depends on the order of updates at the rising edge.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (sent_bytes % 100 == 0)
            in_quiet = ($urandom_range(0, 3) == 0);
        gap = pick_gap(in_quiet);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        do
            @(negedge clk);
        while (!in_ready);
        @(posedge clk);
        sent_bytes++;
        // Bytes dropped during the hunt do not count toward the stimulus volume.
        if (phase == PH_LENGTH || phase == PH_BODY)
            counted_items++;
        decode_byte(b);
    endtask

    // One repetition group. Noise level 1 corrupts at most two copies, which the vote
    // must repair; level 2 scrambles copies freely, so the vote may come out wrong.
    task automatic send_group(input logic [7:0] value, input int noise);
        int         bad_a;
        int         bad_b;
        logic [7:0] copy;
        bad_a = (noise > 0) ? $urandom_range(0, RF - 1) : -1;
        bad_b = (noise > 0 && $urandom_range(0, 1) == 1) ? $urandom_range(0, RF - 1) : -1;
        for (int k = 0; k < RF; k++) begin
            copy = value;
            if (noise >= 2 && $urandom_range(0, 1) == 1)
                copy = 8'($urandom);
            else if (k == bad_a || k == bad_b)
                copy = value ^ 8'($urandom_range(1, 255));
            send_byte(copy);
        end
    endtask

    // A complete frame with random payload. The length group never gets heavy noise,
    // so a scrambled length cannot swallow hundreds of following bytes.
    task automatic send_frame(input int len, input bit bad_crc, input int noise);
        logic [7:0]  b;
        logic [15:0] crc;
        int          r;
        crc = rcfr_pkg::CRC_INIT;
        send_byte(start_byte_cfg);
        send_group(8'(len), (noise > 1) ? 1 : noise);
        if (phase != PH_BODY)
            return;
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 7);
            if (r == 0)
                b = start_byte_cfg;
            else if (r == 1)
                b = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
            else
                b = 8'($urandom);
            crc = crc16_next(crc, b);
            send_group(b, noise);
        end
        if (bad_crc)
            crc ^= 16'(1) << $urandom_range(0, 15);
        send_group(crc[7:0], noise);
        send_group(crc[15:8], noise);
    endtask

    // Feeds zeros until any frame in progress is closed, so the block is back in the hunt.
    task automatic close_frame();
        while (phase == PH_LENGTH || phase == PH_BODY)
            send_byte(8'h00);
    endtask

    // Stops the input and waits until every owed result has been taken. A group can
    // finish without a result, so the task lets the clock run on after the queue empties.
    task automatic settle_idle();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One register write transaction; valid drops at the accepting edge and the task
    // then waits for another edge, so back-to-back writes never assign twice in a step.
    task automatic write_reg(input logic idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(negedge clk);
        while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == rcfr_pkg::CFG_START_BYTE)
            start_byte_cfg = value;
        else
            max_length_cfg = value;
        @(posedge clk);
    endtask

    // Mostly well-formed frames with random content and noise, plus bad lengths,
    // hunt noise and frames cut short, until the budget of counted bytes is spent.
    task automatic random_traffic(input int budget);
        int goal;
        int r;
        int cap;
        int len;
        int noise;
        goal = counted_items + budget;
        cap  = (max_length_cfg == 8'd0) ? 6 : max_length_cfg;
        while (counted_items < goal) begin
            r = $urandom_range(0, 99);
            noise = $urandom_range(0, 9);
            noise = (noise < 5) ? 0 : (noise < 9) ? 1 : 2;
            if (r < 70) begin
                if ($urandom_range(0, 99) < 85)
                    len = $urandom_range(1, (cap < 6) ? cap : 6);
                else
                    len = $urandom_range(1, (cap < 40) ? cap : 40);
                send_frame(len, $urandom_range(0, 4) == 0, noise);
            end else if (r < 80) begin
                if (max_length_cfg == 8'hFF || $urandom_range(0, 2) == 0)
                    len = 0;
                else
                    len = $urandom_range(max_length_cfg + 1, 255);
                send_frame(len, 1'b0, (noise > 1) ? 1 : noise);
            end else if (r < 90) begin
                repeat ($urandom_range(1, 8))
                    send_byte(8'($urandom));
            end else begin
                send_byte(start_byte_cfg);
                repeat ($urandom_range(1, 12))
                    send_byte(8'($urandom));
            end
        end
        close_frame();
    endtask

    // Reset configuration: a dropped byte, a zero length whose copies disagree in every
    // bit, and a one-byte frame whose payload equals the start byte.
    task automatic test_directed_frames();
        logic [15:0] crc;
        crc = crc16_next(rcfr_pkg::CRC_INIT, rcfr_pkg::START_BYTE_RESET);
        send_byte(8'hFF);
        send_byte(rcfr_pkg::START_BYTE_RESET);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(rcfr_pkg::START_BYTE_RESET);
        send_group(8'd1, 1);
        send_group(rcfr_pkg::START_BYTE_RESET, 0);
        send_group(crc[7:0], 1);
        send_group(crc[15:8], 0);
    endtask

    task automatic test_random_default();
        random_traffic(500);
    endtask

    // Register extremes, a small limit to stress the length boundary, and a zero limit
    // under which every length is a framing error.
    task automatic test_register_extremes();
        logic [7:0] starts [4];
        logic [7:0] limits [4];
        int         budgets [4];
        starts  = '{8'h00, 8'hFF, 8'h5A, rcfr_pkg::START_BYTE_RESET};
        limits  = '{8'd1, 8'd255, 8'd3, 8'd0};
        budgets = '{220, 220, 220, 80};
        for (int i = 0; i < 4; i++) begin
            settle_idle();
            write_reg(rcfr_pkg::CFG_START_BYTE, starts[i]);
            write_reg(rcfr_pkg::CFG_MAX_LENGTH, limits[i]);
            random_traffic(budgets[i]);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %h, got %h", name, want, got);
        end
    endtask

    // Result side: random stalls, with quiet stretches where the receiver never stalls.
    always @(posedge clk) begin
        out_cycles++;
        if (out_cycles % 256 == 0)
            out_quiet = ($urandom_range(0, 3) == 0);
        if (out_stall_left > 0) begin
            out_ready <= 1'b0;
            out_stall_left--;
        end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 2) == 0)
                out_stall_left = pick_gap(out_quiet);
        end
    end

    // Each result transaction is compared with the oldest owed result, field by field.
    always @(negedge clk) begin : check_results
        rcfr_pkg::result_t want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: kind %0d data %h", result_kind, data_byte);
            end else begin
                want = expected_results.pop_front();
                check_field("result_kind", want.kind, result_kind);
                check_field("data_byte", want.data, data_byte);
                check_field("last", want.last, last);
                check_field("crc_received", want.crc_rx, crc_received);
                check_field("crc_computed", want.crc_local, crc_computed);
                check_field("ok_total", want.ok_total, ok_total);
                check_field("crc_error_total", want.crc_error_total, crc_error_total);
                check_field("framing_error_total", want.framing_error_total,
                            framing_error_total);
                check_field("corrected_total", want.corrected_total, corrected_total);
            end
        end
    end

    // Watchdog: ends the run when no channel completes a transaction for too long.
    always @(negedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
            || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        reset_decoder();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_frames();
        test_random_default();
        test_register_extremes();
        settle_idle();
        repeat (4) @(posedge clk);

        if (mismatches == 0 && expected_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
